// ===== rtl/sorted_deadline_timer_queue_unit_macros.svh =====
// Assertion helpers for the timer queue checker.
// Each macro expects clk in scope; SDTQ_ASSERT also expects rst_n.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH

// Checked only outside reset.
`define SDTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define SDTQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sdtq_pkg.sv =====
`timescale 1ns / 1ps
package sdtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 20;
  localparam int HID_W       = 8;
  localparam int ARG_W       = 16;
  localparam int RC_W        = 5;
  localparam int TTN_W       = 20;
  localparam int KIND_W      = 3;
  localparam int CMD_W       = 2;

  localparam int RC_MAX = (1 << RC_W) - 1;
  localparam logic [TTN_W-1:0] TTN_MAX = {TTN_W{1'b1}};
  // most entries one tick may fire
  localparam logic [CNT_W-1:0] FIRE_CAP =
    CNT_W'((MAX_RESULTS < QUEUE_DEPTH) ? MAX_RESULTS : QUEUE_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED       = 3'd0,
    KIND_REJECTED    = 3'd1,
    KIND_DEL_DONE    = 3'd2,
    KIND_FIRED       = 3'd3,
    KIND_NOTHING_DUE = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_FRONT_RD,
    ST_FRONT_CALC,
    ST_EMIT_RD,
    ST_EMIT,
    ST_RESULT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic start;
    logic walk;
    logic front_rd;
    logic front_calc;
    logic emit_rd;
    logic emit_ld;
    logic result_ld;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic walk_done;
    logic out_free;
    logic emit_last;
    logic fired_any;
  } dp_stat_t;

endpackage

// ===== rtl/sdtq_ifs.sv =====
`timescale 1ns / 1ps
interface sdtq_in_if import sdtq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [DELAY_W-1:0] delay_ms;
  logic [HID_W-1:0]   handler_id;
  logic [ARG_W-1:0]   arg_tag;

  modport source (output valid, cmd, delay_ms, handler_id, arg_tag, input ready);
  modport sink   (input valid, cmd, delay_ms, handler_id, arg_tag, output ready);
endinterface

interface sdtq_out_if import sdtq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [HID_W-1:0]  fired_handler;
  logic [ARG_W-1:0]  fired_arg;
  logic [RC_W-1:0]   removed_count;
  logic [TTN_W-1:0]  time_to_next;
  logic              last;

  modport source (output valid, kind, fired_handler, fired_arg, removed_count,
                  time_to_next, last, input ready);
  modport sink   (input valid, kind, fired_handler, fired_arg, removed_count,
                  time_to_next, last, output ready);
endinterface

// ===== rtl/sdtq_ctrl.sv =====
`timescale 1ns / 1ps
module sdtq_ctrl import sdtq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        if (dp_stat.cmd == CMD_NOP) begin
          state_nxt = ST_IDLE;
        end else if (dp_stat.cmd == CMD_ADD && dp_stat.full) begin
          state_nxt = ST_FRONT_RD;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (dp_stat.walk_done) state_nxt = ST_FRONT_RD;
      end
      ST_FRONT_RD:   state_nxt = ST_FRONT_CALC;
      ST_FRONT_CALC: begin
        if (dp_stat.cmd == CMD_TICK && dp_stat.fired_any) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_EMIT_RD:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (dp_stat.out_free) begin
          state_nxt = dp_stat.emit_last ? ST_FIN : ST_EMIT_RD;
        end
      end
      ST_RESULT: begin
        if (dp_stat.out_free) state_nxt = ST_FIN;
      end
      ST_FIN:        state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd   = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        dp_cmd.latch = in_valid;
      end
      ST_START:      dp_cmd.start      = 1'b1;
      ST_WALK:       dp_cmd.walk       = 1'b1;
      ST_FRONT_RD:   dp_cmd.front_rd   = 1'b1;
      ST_FRONT_CALC: dp_cmd.front_calc = 1'b1;
      ST_EMIT_RD:    dp_cmd.emit_rd    = 1'b1;
      ST_EMIT:       dp_cmd.emit_ld    = dp_stat.out_free;
      ST_RESULT:     dp_cmd.result_ld  = dp_stat.out_free;
      ST_FIN:        dp_cmd.commit     = 1'b1;
      default: begin
        dp_cmd   = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/sdtq_datapath.sv =====
`timescale 1ns / 1ps
module sdtq_datapath import sdtq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            dp_cmd,
  output dp_stat_t           dp_stat,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [DELAY_W-1:0] in_delay_ms,
  input  logic [HID_W-1:0]   in_handler_id,
  input  logic [ARG_W-1:0]   in_arg_tag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [HID_W-1:0]   out_fired_handler,
  output logic [ARG_W-1:0]   out_fired_arg,
  output logic [RC_W-1:0]    out_removed_count,
  output logic [TTN_W-1:0]   out_time_to_next,
  output logic               out_last
);

  localparam int SUM_W  = CNT_W + 1;
  localparam int WIDE_W = (CNT_W > RC_W) ? CNT_W : RC_W;

  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [HID_W-1:0]  hid;
    logic [ARG_W-1:0]  arg;
  } entry_t;

  // queue position -> ring slot
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(idx);
    if (sum >= SUM_W'(QUEUE_DEPTH)) sum = sum - SUM_W'(QUEUE_DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  // a strictly later than b, by sign of the wrapping difference
  function automatic logic later(input logic [TIME_W-1:0] a,
                                 input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;

  // control state
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  head_r;
  logic [TIME_W-1:0] time_r;
  logic              out_valid_r;

  // item and walk state
  cmd_t              cmd_r;
  logic [TIME_W-1:0] dl_r;
  logic [HID_W-1:0]  hid_r;
  logic [ARG_W-1:0]  arg_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  w_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  e_r;
  logic              ins_r;
  logic              rej_r;
  entry_t            held_r;
  logic [RC_W-1:0]   rc_r;
  logic [TTN_W-1:0]  ttn_r;

  // result register
  logic [KIND_W-1:0] kind_r;
  logic [HID_W-1:0]  ohid_r;
  logic [ARG_W-1:0]  oarg_r;
  logic [RC_W-1:0]   orc_r;
  logic [TTN_W-1:0]  ottn_r;
  logic              olast_r;

  logic              rd_en;
  logic [CNT_W-1:0]  rd_idx;
  logic              wr_en;
  logic [CNT_W-1:0]  wr_idx;
  entry_t            wr_data;
  entry_t            new_entry;
  logic              in_range, at_end, place, keep, due, walk_done;
  logic [CNT_W-1:0]  removed;
  logic [WIDE_W-1:0] removed_w;
  logic [RC_W-1:0]   rc_nxt;
  logic [TIME_W-1:0] front_gap;
  logic [TTN_W-1:0]  ttn_nxt;
  logic              emit_last;
  logic              out_free;
  kind_t             res_kind;

  assign new_entry = '{dl: dl_r, hid: hid_r, arg: arg_r};
  assign in_range  = i_r < count_r;
  assign at_end    = i_r == count_r;
  assign place     = !ins_r && (at_end || later(rd_q.dl, dl_r));
  assign keep      = in_range && (rd_q.hid != hid_r);
  assign due       = in_range && (i_r < FIRE_CAP) && !later(rd_q.dl, time_r);
  assign emit_last = (e_r + CNT_W'(1)) == k_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd_r)
      CMD_ADD, CMD_DEL: walk_done = at_end;
      CMD_TICK:         walk_done = !due;
      default:          walk_done = 1'b1;
    endcase
  end

  always_comb begin
    rd_en  = dp_cmd.start | dp_cmd.walk | dp_cmd.front_rd | dp_cmd.emit_rd;
    rd_idx = e_r;
    if (dp_cmd.start) begin
      rd_idx = '0;
    end else if (dp_cmd.walk) begin
      rd_idx = i_r + CNT_W'(1);
    end else if (dp_cmd.front_rd) begin
      rd_idx = k_r;
    end
  end

  // add: ripple entries one slot back from the insert point
  // delete: compact kept entries toward the front
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = i_r;
    wr_data = rd_q;
    if (dp_cmd.walk) begin
      case (cmd_r)
        CMD_ADD: begin
          wr_en   = place || ins_r;
          wr_data = place ? new_entry : held_r;
        end
        CMD_DEL: begin
          wr_en  = keep;
          wr_idx = w_r;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_comb begin
    removed   = count_r - w_r;
    removed_w = WIDE_W'(removed);
    rc_nxt    = (removed_w > WIDE_W'(RC_MAX)) ? RC_W'(RC_MAX) : RC_W'(removed_w);
  end

  always_comb begin
    front_gap = rd_q.dl - time_r;
    if (count_r == k_r) begin
      ttn_nxt = '0;
    end else if (front_gap == '0 || front_gap[TIME_W-1]) begin
      ttn_nxt = TTN_W'(1);
    end else if (front_gap > TIME_W'(TTN_MAX)) begin
      ttn_nxt = TTN_MAX;
    end else begin
      ttn_nxt = front_gap[TTN_W-1:0];
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_ADD: res_kind = rej_r ? KIND_REJECTED : KIND_ADDED;
      CMD_DEL: res_kind = KIND_DEL_DONE;
      default: res_kind = KIND_NOTHING_DUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[phys(head_r, wr_idx)] <= wr_data;
    if (rd_en) rd_q <= mem[phys(head_r, rd_idx)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (dp_cmd.latch && cmd_t'(in_cmd) == CMD_TICK) time_r <= time_r + TIME_W'(1);
      if (dp_cmd.walk && walk_done) begin
        case (cmd_r)
          CMD_ADD: count_r <= count_r + CNT_W'(1);
          CMD_DEL: count_r <= w_r;
          default: count_r <= count_r;
        endcase
      end
      if (dp_cmd.commit) begin
        count_r <= count_r - k_r;
        head_r  <= phys(head_r, k_r);
      end
      if (dp_cmd.emit_ld || dp_cmd.result_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.latch) begin
      cmd_r <= cmd_t'(in_cmd);
      hid_r <= in_handler_id;
      arg_r <= in_arg_tag;
      dl_r  <= time_r + TIME_W'(in_delay_ms);
      k_r   <= '0;
      rc_r  <= '0;
    end
    if (dp_cmd.start) begin
      i_r   <= '0;
      w_r   <= '0;
      ins_r <= 1'b0;
      rej_r <= (cmd_r == CMD_ADD) && (count_r == CNT_W'(QUEUE_DEPTH));
    end
    if (dp_cmd.walk) begin
      i_r <= i_r + CNT_W'(1);
      case (cmd_r)
        CMD_ADD: begin
          if (place || ins_r) held_r <= rd_q;
          if (place) ins_r <= 1'b1;
        end
        CMD_DEL: begin
          if (keep) w_r <= w_r + CNT_W'(1);
          if (at_end) rc_r <= rc_nxt;
        end
        CMD_TICK: begin
          if (due) k_r <= k_r + CNT_W'(1);
        end
        default: ;
      endcase
    end
    if (dp_cmd.front_calc) begin
      ttn_r <= ttn_nxt;
      e_r   <= '0;
    end
    if (dp_cmd.emit_ld) begin
      e_r     <= e_r + CNT_W'(1);
      kind_r  <= KIND_FIRED;
      ohid_r  <= rd_q.hid;
      oarg_r  <= rd_q.arg;
      orc_r   <= '0;
      ottn_r  <= ttn_r;
      olast_r <= emit_last;
    end else if (dp_cmd.result_ld) begin
      kind_r  <= res_kind;
      ohid_r  <= '0;
      oarg_r  <= '0;
      orc_r   <= rc_r;
      ottn_r  <= ttn_r;
      olast_r <= 1'b1;
    end
  end

  assign dp_stat.cmd       = cmd_r;
  assign dp_stat.full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign dp_stat.walk_done = walk_done;
  assign dp_stat.out_free  = out_free;
  assign dp_stat.emit_last = emit_last;
  assign dp_stat.fired_any = k_r != '0;

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_fired_handler = ohid_r;
  assign out_fired_arg     = oarg_r;
  assign out_removed_count = orc_r;
  assign out_time_to_next  = ottn_r;
  assign out_last          = olast_r;

endmodule

// ===== rtl/sorted_deadline_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// Deadline-sorted timer queue with a millisecond clock.
// in_chan (valid/ready) takes one command per transaction: add an entry
// (deadline = now + delay_ms), delete all entries of a handler, or a
// one-millisecond tick. out_chan (valid/ready) returns results; last marks
// the final result of a command. Add and delete give one result, a tick
// gives one result per fired entry (up to 16) or a single nothing-due result.
// Every result carries time_to_next, the distance to the front deadline once
// the command is done.
// Timing: the queue sits in a ring memory with one read and one write port;
// add and delete walk the whole queue one entry per cycle; a tick walks only
// the due entries, then reads and emits each fired entry in turn. A full-queue
// add skips the walk.
// An unused command code is taken and dropped with no result.
// Reset empties the queue and zeroes the clock; the ring itself is not
// cleared since data read from unoccupied slots is never used. A stalled out_chan holds
// its result in the output register; the controller waits there, and a new
// input transaction is taken once the current command has fully retired.
module sorted_deadline_timer_queue_unit import sdtq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  sdtq_in_if.sink    in_chan,
  sdtq_out_if.source out_chan
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: accept, walk, front lookup, result delivery, commit
  sdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  // ring memory, clock, counters and the output register
  sdtq_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_cmd            (dp_cmd),
    .dp_stat           (dp_stat),
    .in_cmd            (in_chan.cmd),
    .in_delay_ms       (in_chan.delay_ms),
    .in_handler_id     (in_chan.handler_id),
    .in_arg_tag        (in_chan.arg_tag),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_kind          (out_chan.kind),
    .out_fired_handler (out_chan.fired_handler),
    .out_fired_arg     (out_chan.fired_arg),
    .out_removed_count (out_chan.removed_count),
    .out_time_to_next  (out_chan.time_to_next),
    .out_last          (out_chan.last)
  );

endmodule

// ===== rtl/sdtq_checker.sv =====
`timescale 1ns / 1ps
`include "sorted_deadline_timer_queue_unit_macros.svh"
module sdtq_checker import sdtq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  sdtq_in_if.sink    in_chan,
  sdtq_out_if.source out_chan
);

  `SDTQ_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_chan.valid && in_chan.ready), "not idle after reset")

  `SDTQ_ASSERT(a_out_hold, (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(out_chan.kind) && $stable(out_chan.fired_arg) && $stable(out_chan.time_to_next) && $stable(out_chan.last)), "stalled result changed")

  `SDTQ_ASSERT(a_single_result, (out_chan.valid && out_chan.kind != KIND_FIRED) |-> (out_chan.last && out_chan.fired_handler == '0 && out_chan.fired_arg == '0), "non-fire result malformed")

  `SDTQ_ASSERT(a_count_delete_only, (out_chan.valid && out_chan.kind != KIND_DEL_DONE) |-> (out_chan.removed_count == '0), "removed count outside delete")

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
